// ===== design/mm2h_pkg.sv =====
// Shared constants, types and command/status structs for the MurmurHash2 block.
package mm2h_pkg;

    // Hash constants
    localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
    localparam int          MIX_SHIFT   = 24;
    localparam int          FIN_SHIFT_A = 13;
    localparam int          FIN_SHIFT_B = 15;

    // Field widths
    localparam int WORD_W  = 32;
    localparam int NB_W    = 3;
    localparam int KLEN_W  = 32;
    localparam int HASH_W  = 32;
    localparam int IN_BITS = WORD_W + NB_W + KLEN_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    // Byte-count codes
    localparam logic [NB_W-1:0] NB_ZERO = 3'd0;
    localparam logic [NB_W-1:0] NB_ONE  = 3'd1;
    localparam logic [NB_W-1:0] NB_TWO  = 3'd2;
    localparam logic [NB_W-1:0] NB_FOUR = 3'd4;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MIX1,
        S_MIX2,
        S_MIX3,
        S_MIX4,
        S_TAIL1,
        S_TAIL2,
        S_FIN1,
        S_FIN2
    } state_t;

    // Multiplier operand select
    typedef enum logic [2:0] {
        MUL_WORD,
        MUL_KMIX,
        MUL_HASH,
        MUL_TAIL,
        MUL_FIN
    } mul_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic     capture;     // latch the incoming item
        logic     load_seed;   // start a new key: h = seed ^ key_length
        logic     mul_en;      // load product register
        mul_sel_t mul_sel;
        logic     k_save;      // park mixed word k in the word register
        logic     h_from_mix;  // h = product ^ k
        logic     h_from_prod; // h = product
        logic     out_load;    // finalize product into output register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_full;  // incoming item carries four or more bytes
        logic in_zero;  // incoming item carries no bytes
    } dp_status_t;

endpackage

// ===== design/mm2h_datapath.sv =====
// Datapath: item registers, running hash, shared multiplier and output register.
module mm2h_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [mm2h_pkg::IN_TDATA_W-1:0]     in_data,
    input  logic                                seed_we,
    input  logic [mm2h_pkg::HASH_W-1:0]         seed_data,
    input  mm2h_pkg::dp_cmd_t                   cmd,
    output mm2h_pkg::dp_status_t                status,
    output logic [mm2h_pkg::HASH_W-1:0]         hash_out
);
    import mm2h_pkg::*;

    logic [WORD_W-1:0] in_word;
    logic [NB_W-1:0]   in_nb;
    logic [KLEN_W-1:0] in_klen;
    logic [NB_W-1:0]   in_nb_sat;

    logic [HASH_W-1:0] seed_reg;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [NB_W-1:0]   nb_reg;
    logic [HASH_W-1:0] h_reg, h_next;
    logic [HASH_W-1:0] prod_reg, prod_next;
    logic [HASH_W-1:0] out_reg, out_next;

    logic [WORD_W-1:0] tail_mask;
    logic [HASH_W-1:0] mul_a;

    // Unpack the input item
    assign in_word   = in_data[WORD_W-1:0];
    assign in_nb     = in_data[WORD_W+NB_W-1:WORD_W];
    assign in_klen   = in_data[IN_BITS-1:WORD_W+NB_W];
    assign in_nb_sat = (in_nb > NB_FOUR) ? NB_FOUR : in_nb;

    assign status.in_full = (in_nb >= NB_FOUR);
    assign status.in_zero = (in_nb == NB_ZERO);

    // Seed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (seed_we)
        begin
            seed_reg <= seed_data;
        end
    end

    // Tail byte mask
    always_comb
    begin
        unique case (nb_reg)
            NB_ONE:  tail_mask = 32'h0000_00ff;
            NB_TWO:  tail_mask = 32'h0000_ffff;
            default: tail_mask = 32'h00ff_ffff;
        endcase
    end

    // Shared multiplier operand
    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_WORD: mul_a = word_reg;
            MUL_KMIX: mul_a = prod_reg ^ (prod_reg >> MIX_SHIFT);
            MUL_HASH: mul_a = h_reg;
            MUL_TAIL: mul_a = h_reg ^ (word_reg & tail_mask);
            MUL_FIN:  mul_a = h_reg ^ (h_reg >> FIN_SHIFT_A);
            default:  mul_a = h_reg;
        endcase
    end

    // Next values
    always_comb
    begin
        prod_next = cmd.mul_en ? HASH_W'(mul_a * MIX_MUL) : prod_reg;

        word_next = word_reg;
        if (cmd.capture)
            word_next = in_word;
        else if (cmd.k_save)
            word_next = prod_reg;

        h_next = h_reg;
        if (cmd.load_seed)
            h_next = seed_reg ^ in_klen;
        else if (cmd.h_from_mix)
            h_next = prod_reg ^ word_reg;
        else if (cmd.h_from_prod)
            h_next = prod_reg;

        out_next = cmd.out_load ? (prod_reg ^ (prod_reg >> FIN_SHIFT_B)) : out_reg;
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        h_reg    <= h_next;
        prod_reg <= prod_next;
        out_reg  <= out_next;
        if (cmd.capture)
            nb_reg <= in_nb_sat;
    end

    assign hash_out = out_reg;

endmodule

// ===== design/mm2h_ctrl.sv =====
// Controller: sequences word mix, tail and finalization steps; owns handshakes.
module mm2h_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_last,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  mm2h_pkg::dp_status_t  status,
    output mm2h_pkg::dp_cmd_t     cmd
);
    import mm2h_pkg::*;

    state_t state_reg, state_next;
    logic   in_key_reg, in_key_next;
    logic   last_reg, last_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_key_reg    <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_key_reg    <= in_key_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        in_key_next    = in_key_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.mul_sel    = MUL_HASH;

        // result taken downstream
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture   = 1'b1;
                    cmd.load_seed = !in_key_reg;
                    last_next     = in_last;
                    in_key_next   = 1'b1;
                    if (status.in_full)
                        state_next = S_MIX1;
                    else if (!status.in_zero)
                        state_next = S_TAIL1;
                    else if (in_last)
                        state_next = S_FIN1;
                end
            end
            S_MIX1:
            begin
                // p = w * M
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_WORD;
                state_next  = S_MIX2;
            end
            S_MIX2:
            begin
                // p = (p ^ p >> 24) * M
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_KMIX;
                state_next  = S_MIX3;
            end
            S_MIX3:
            begin
                // park k, p = h * M
                cmd.k_save  = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_HASH;
                state_next  = S_MIX4;
            end
            S_MIX4:
            begin
                cmd.h_from_mix = 1'b1;
                state_next     = last_reg ? S_FIN1 : S_IDLE;
            end
            S_TAIL1:
            begin
                // p = (h ^ tail bytes) * M
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_TAIL;
                state_next  = S_TAIL2;
            end
            S_TAIL2:
            begin
                cmd.h_from_prod = 1'b1;
                state_next      = last_reg ? S_FIN1 : S_IDLE;
            end
            S_FIN1:
            begin
                // p = (h ^ h >> 13) * M
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_FIN;
                state_next  = S_FIN2;
            end
            S_FIN2:
            begin
                // wait for a free output register
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    in_key_next    = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // a finished hash never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten");

    // a free output register gets the finished hash next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN2 && !out_valid_reg) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("finalized hash not delivered");

    // a full word goes to the mixer
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && status.in_full) |=> (state_reg == S_MIX1 && in_key_reg))
        else $error("full word not mixed");

    // a key that continues stays open after its word step
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_MIX4 || state_reg == S_TAIL2) && !last_reg)
            |=> (state_reg == S_IDLE && in_key_reg))
        else $error("key closed early");
`endif

endmodule

// ===== design/murmur2_hash_32.sv =====
// Top level of the streaming 32-bit MurmurHash2 block.
// Computes the 32-bit MurmurHash2 of a key streamed as little-endian words.
// All math runs through one shared 32x32 multiplier (low half kept) with a
// registered product, so the cost per item is set by how many multiplies it
// needs: a four-byte word is accepted, then takes three multiplies and an
// xor, a one- to three-byte tail takes one multiply, an empty item is only
// accepted, and the last item adds finalization before the hash lands in the
// output register. The next key may start while a finished hash waits to be taken.
// The seed is taken from cfg_data at any cfg_valid write and applies from the
// next key's first item on; key_length is read only on that first item.
module murmur2_hash_32 (
    input  logic                                clk,
    input  logic                                rst_n,
    // seed write
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mm2h_pkg::HASH_W-1:0]         cfg_data,   // hash_seed
    // key stream in
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // data_word[31:0], bytes_valid[34:32], key_length[66:35], zero[71:67]
    input  logic [mm2h_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                                s_axis_tlast, // last_item
    // hash out
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [mm2h_pkg::HASH_W-1:0]         m_axis_tdata // hash_value[31:0]
);
    import mm2h_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       seed_we;

    // seed writes are always taken
    assign cfg_ready = 1'b1;
    assign seed_we   = cfg_valid && cfg_ready;

    mm2h_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_last   (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    mm2h_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .seed_we   (seed_we),
        .seed_data (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .hash_out  (m_axis_tdata)
    );

endmodule
